[hdl/accel_tilt_roll_pitch_top_macros.svh]
// Assertion macros shared by the tilt block's checker.
`ifndef ACCEL_TILT_ROLL_PITCH_TOP_MACROS_SVH
`define ACCEL_TILT_ROLL_PITCH_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define ATRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define ATRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/atrp_pkg.sv]
// Shared widths, constants and word types of the tilt block.
package atrp_pkg;

  localparam int SAMPLE_W    = 16;                  // raw accelerometer sample
  localparam int ANGLE_W     = 16;                  // degrees * 128
  localparam int FRAC_W      = 8;                   // fraction bits of atan2 operands
  localparam int SQ_W        = 2 * SAMPLE_W;        // sum of two squares
  localparam int RAD_W       = SQ_W + 2 * FRAC_W;   // sqrt radicand
  localparam int ROOT_W      = RAD_W / 2;           // sqrt result
  localparam int OP_W        = ROOT_W + 2;          // signed atan2 operand
  localparam int ATAN_ENTRIES = 24;
  localparam int ANGLE_LIMIT = 23040;               // 180 degrees * 128

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
  } in_word_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
  } out_word_t;

  // sample and mode riding along the squaring and sqrt stages
  typedef struct packed {
    logic                       mode;
    logic signed [SAMPLE_W-1:0] ax;
    logic signed [SAMPLE_W-1:0] ay;
    logic signed [SAMPLE_W-1:0] az;
  } side_t;

endpackage

[hdl/atrp_isqrt.sv]
// Pipelined integer square root of (sum << 16), one root bit per stage.
module atrp_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [atrp_pkg::SQ_W-1:0]   in_sum,
  input  atrp_pkg::side_t             in_side,
  output logic                        out_valid,
  output logic [atrp_pkg::ROOT_W-1:0] out_root,
  output atrp_pkg::side_t             out_side
);

  localparam int SQ_W   = atrp_pkg::SQ_W;
  localparam int RAD_W  = atrp_pkg::RAD_W;
  localparam int ROOT_W = atrp_pkg::ROOT_W;
  localparam int PAD_W  = RAD_W - SQ_W;
  localparam int REM_W  = ROOT_W + 2;

  logic                  vld_r  [ROOT_W];
  logic [REM_W-1:0]      rem_r  [ROOT_W];
  logic [ROOT_W-1:0]     root_r [ROOT_W];
  logic [SQ_W-1:0]       sum_r  [ROOT_W];
  atrp_pkg::side_t       side_r [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic              cur_vld;
    logic [REM_W-1:0]  cur_rem;
    logic [ROOT_W-1:0] cur_root;
    logic [SQ_W-1:0]   cur_sum;
    atrp_pkg::side_t   cur_side;
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (j == 0) begin : g_first
      assign cur_vld  = in_valid;
      assign cur_rem  = '0;
      assign cur_root = '0;
      assign cur_sum  = in_sum;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_vld  = vld_r[j-1];
      assign cur_rem  = rem_r[j-1];
      assign cur_root = root_r[j-1];
      assign cur_sum  = sum_r[j-1];
      assign cur_side = side_r[j-1];
    end

    // restoring step: bring down two radicand bits, try root*4+1
    always_comb begin
      rad      = {cur_sum, PAD_W'(0)};
      rem_sh   = {cur_rem[REM_W-3:0], rad[RAD_W-1-2*j -: 2]};
      trial    = {cur_root, 2'b01};
      take     = (rem_sh >= trial);
      rem_nxt  = take ? (rem_sh - trial) : rem_sh;
      root_nxt = {cur_root[ROOT_W-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_nxt;
        root_r[j] <= root_nxt;
        sum_r[j]  <= cur_sum;
        side_r[j] <= cur_side;
      end
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];

endmodule

[hdl/atrp_cordic.sv]
// Pipelined atan2 by CORDIC vectoring, output in degrees * 128.
module atrp_cordic #(
  parameter int STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [atrp_pkg::OP_W-1:0]  in_num,
  input  logic signed [atrp_pkg::OP_W-1:0]  in_den,
  output logic                              out_valid,
  output logic signed [atrp_pkg::ANGLE_W-1:0] out_angle
);

  localparam int OP_W     = atrp_pkg::OP_W;
  localparam int ANGLE_W  = atrp_pkg::ANGLE_W;
  localparam int NSTG     = (STAGES > atrp_pkg::ATAN_ENTRIES) ? atrp_pkg::ATAN_ENTRIES
                                                              : STAGES;
  localparam int NORM_MSB = 40;                 // larger magnitude lands in [2^40, 2^41)
  localparam int CORDIC_W = NORM_MSB + 6;       // room for sign, 90 deg turn and gain
  localparam int SH_W     = $clog2(NORM_MSB + 1);
  localparam int Z_W      = 26;                 // degrees * 2^16 plus margin
  localparam int QUARTER  = 90 * 65536;
  localparam int RND_BIAS = 256;
  localparam int OUT_SH   = 9;

  localparam logic signed [Z_W-1:0] LIM_POS = Z_W'(atrp_pkg::ANGLE_LIMIT);
  localparam logic signed [Z_W-1:0] LIM_NEG = Z_W'(-atrp_pkg::ANGLE_LIMIT);

  // atan(2^-i) in degrees * 2^16
  function automatic logic signed [Z_W-1:0] atan_deg16(input int idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      0:       v = Z_W'(2949120);
      1:       v = Z_W'(1740967);
      2:       v = Z_W'(919879);
      3:       v = Z_W'(466945);
      4:       v = Z_W'(234379);
      5:       v = Z_W'(117304);
      6:       v = Z_W'(58666);
      7:       v = Z_W'(29335);
      8:       v = Z_W'(14668);
      9:       v = Z_W'(7334);
      10:      v = Z_W'(3667);
      11:      v = Z_W'(1833);
      12:      v = Z_W'(917);
      13:      v = Z_W'(458);
      14:      v = Z_W'(229);
      15:      v = Z_W'(115);
      16:      v = Z_W'(57);
      17:      v = Z_W'(29);
      18:      v = Z_W'(14);
      19:      v = Z_W'(7);
      20:      v = Z_W'(4);
      21:      v = Z_W'(2);
      22:      v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

  // stage A: magnitudes, larger one, zero vector
  logic                   a_vld_r, a_zero_r, a_zero_nxt;
  logic signed [OP_W-1:0] a_x_r, a_y_r;
  logic [OP_W-1:0]        a_m_r, a_m_nxt, a_mag_num, a_mag_den;

  always_comb begin
    a_mag_num  = in_num[OP_W-1] ? OP_W'(-in_num) : OP_W'(in_num);
    a_mag_den  = in_den[OP_W-1] ? OP_W'(-in_den) : OP_W'(in_den);
    a_m_nxt    = (a_mag_den > a_mag_num) ? a_mag_den : a_mag_num;
    a_zero_nxt = (in_num == '0) && (in_den == '0);
  end

  // stage B: shift count and quarter turn for a negative x
  logic                   b_vld_r, b_zero_r;
  logic signed [OP_W-1:0] b_x_r, b_y_r, b_x_nxt, b_y_nxt;
  logic signed [Z_W-1:0]  b_z_r, b_z_nxt;
  logic [SH_W-1:0]        b_k_r, b_k_nxt, b_msb;

  always_comb begin
    b_msb = '0;
    for (int b = 0; b < OP_W; b++) begin
      if (a_m_r[b]) b_msb = SH_W'(b);
    end
    b_k_nxt = SH_W'(NORM_MSB) - b_msb;
    if (a_x_r[OP_W-1] && !a_y_r[OP_W-1]) begin
      b_x_nxt = a_y_r;
      b_y_nxt = -a_x_r;
      b_z_nxt = Z_W'(QUARTER);
    end else if (a_x_r[OP_W-1]) begin
      b_x_nxt = -a_y_r;
      b_y_nxt = a_x_r;
      b_z_nxt = Z_W'(-QUARTER);
    end else begin
      b_x_nxt = a_x_r;
      b_y_nxt = a_y_r;
      b_z_nxt = '0;
    end
  end

  // stage C: normalize
  logic                       c_vld_r, c_zero_r;
  logic signed [CORDIC_W-1:0] c_x_r, c_y_r, c_x_nxt, c_y_nxt;
  logic signed [Z_W-1:0]      c_z_r;

  always_comb begin
    c_x_nxt = CORDIC_W'(b_x_r) <<< b_k_r;
    c_y_nxt = CORDIC_W'(b_y_r) <<< b_k_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_valid;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_x_r    <= in_den;
      a_y_r    <= in_num;
      a_m_r    <= a_m_nxt;
      a_zero_r <= a_zero_nxt;
      b_x_r    <= b_x_nxt;
      b_y_r    <= b_y_nxt;
      b_z_r    <= b_z_nxt;
      b_k_r    <= b_k_nxt;
      b_zero_r <= a_zero_r;
      c_x_r    <= c_x_nxt;
      c_y_r    <= c_y_nxt;
      c_z_r    <= b_z_r;
      c_zero_r <= b_zero_r;
    end
  end

  // micro-rotation stages
  logic                       it_vld_r  [NSTG];
  logic                       it_zero_r [NSTG];
  logic signed [CORDIC_W-1:0] it_x_r    [NSTG];
  logic signed [CORDIC_W-1:0] it_y_r    [NSTG];
  logic signed [Z_W-1:0]      it_z_r    [NSTG];

  for (genvar i = 0; i < NSTG; i++) begin : g_iter
    logic                       cur_vld, cur_zero;
    logic signed [CORDIC_W-1:0] cur_x, cur_y, x_nxt, y_nxt;
    logic signed [Z_W-1:0]      cur_z, z_nxt;

    if (i == 0) begin : g_first
      assign cur_vld  = c_vld_r;
      assign cur_zero = c_zero_r;
      assign cur_x    = c_x_r;
      assign cur_y    = c_y_r;
      assign cur_z    = c_z_r;
    end else begin : g_next
      assign cur_vld  = it_vld_r[i-1];
      assign cur_zero = it_zero_r[i-1];
      assign cur_x    = it_x_r[i-1];
      assign cur_y    = it_y_r[i-1];
      assign cur_z    = it_z_r[i-1];
    end

    always_comb begin
      if (!cur_y[CORDIC_W-1]) begin
        x_nxt = cur_x + (cur_y >>> i);
        y_nxt = cur_y - (cur_x >>> i);
        z_nxt = cur_z + atan_deg16(i);
      end else begin
        x_nxt = cur_x - (cur_y >>> i);
        y_nxt = cur_y + (cur_x >>> i);
        z_nxt = cur_z - atan_deg16(i);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        it_vld_r[i] <= 1'b0;
      end else if (en) begin
        it_vld_r[i] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        it_x_r[i]    <= x_nxt;
        it_y_r[i]    <= y_nxt;
        it_z_r[i]    <= z_nxt;
        it_zero_r[i] <= cur_zero;
      end
    end
  end

  // stage F: round to 1/128 degree, clamp, zero vector gives 0
  logic                      f_vld_r;
  logic signed [ANGLE_W-1:0] f_angle_r, f_angle_nxt;
  logic signed [Z_W-1:0]     f_sum, f_deg;

  always_comb begin
    f_sum = it_z_r[NSTG-1] + Z_W'(RND_BIAS);
    f_deg = f_sum >>> OUT_SH;
    if (it_zero_r[NSTG-1]) begin
      f_angle_nxt = '0;
    end else if (f_deg > LIM_POS) begin
      f_angle_nxt = ANGLE_W'(LIM_POS);
    end else if (f_deg < LIM_NEG) begin
      f_angle_nxt = ANGLE_W'(LIM_NEG);
    end else begin
      f_angle_nxt = ANGLE_W'(f_deg);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else if (en) begin
      f_vld_r <= it_vld_r[NSTG-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_angle_r <= f_angle_nxt;
    end
  end

  assign out_valid = f_vld_r;
  assign out_angle = f_angle_r;

endmodule

[hdl/accel_tilt_roll_pitch_top.sv]
// Top level of the accelerometer roll/pitch tilt block.
//
// Takes one three-axis accelerometer word per clock and returns roll and
// pitch in degrees as signed fixed point, 1/128 degree per LSB, clamped to
// +/-180 degrees. With the mode register at 1 (reset value) roll is
// atan2(y, z) and pitch is atan2(-x, |(y, z)|); with 0 roll is
// atan2(y, |(x, z)|) and pitch is atan2(-x, z). A zero vector gives 0.
// The datapath is one fully pipelined chain: input register, squaring,
// sum, a 24-stage square root (one root bit per stage), then two CORDIC
// lanes side by side (magnitude compare, shift count and quarter turn,
// normalize, CORDIC_STAGES micro-rotations capped at 24, round/clamp) and
// an output register. Throughput is one word per clock while in_stall is
// low. A skid register behind the output register absorbs the word in
// flight when out_stall rises, so in_stall follows out_stall in the cycle
// after and no word is lost or repeated.
// The mode register is sampled as each word enters and travels with it;
// cfg_ready is always high.
module accel_tilt_roll_pitch_top #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  atrp_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output atrp_pkg::out_word_t out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  localparam int SAMPLE_W = atrp_pkg::SAMPLE_W;
  localparam int SQ_W     = atrp_pkg::SQ_W;
  localparam int ROOT_W   = atrp_pkg::ROOT_W;
  localparam int OP_W     = atrp_pkg::OP_W;
  localparam int FRAC_W   = atrp_pkg::FRAC_W;

  // pipeline advances whenever the skid register is empty
  logic en;
  logic skid_valid_r, skid_valid_nxt;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // mode register
  logic mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  // s1: input register
  logic            s1_valid_r;
  atrp_pkg::side_t s1_side_r, s1_side_nxt;

  always_comb begin
    s1_side_nxt.mode = mode_r;
    s1_side_nxt.ax   = in_word.accel_x;
    s1_side_nxt.ay   = in_word.accel_y;
    s1_side_nxt.az   = in_word.accel_z;
  end

  // s2: squares of the magnitude operands
  logic                       s2_valid_r;
  atrp_pkg::side_t            s2_side_r;
  logic [SQ_W-1:0]            s2_sq_a_r, s2_sq_b_r, s2_sq_a_nxt, s2_sq_b_nxt;
  logic signed [SAMPLE_W-1:0] mul_a;
  logic signed [SQ_W-1:0]     prod_a, prod_b;

  always_comb begin
    mul_a       = s1_side_r.mode ? s1_side_r.ay : s1_side_r.ax;
    prod_a      = mul_a * mul_a;
    prod_b      = s1_side_r.az * s1_side_r.az;
    s2_sq_a_nxt = $unsigned(prod_a);
    s2_sq_b_nxt = $unsigned(prod_b);
  end

  // s3: sum of squares, fits SQ_W bits
  logic            s3_valid_r;
  atrp_pkg::side_t s3_side_r;
  logic [SQ_W-1:0] s3_sum_r, s3_sum_nxt;

  assign s3_sum_nxt = s2_sq_a_r + s2_sq_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r <= s1_side_nxt;
      s2_side_r <= s1_side_r;
      s2_sq_a_r <= s2_sq_a_nxt;
      s2_sq_b_r <= s2_sq_b_nxt;
      s3_side_r <= s2_side_r;
      s3_sum_r  <= s3_sum_nxt;
    end
  end

  // magnitude with 8 fraction bits
  logic              sq_valid;
  logic [ROOT_W-1:0] sq_root;
  atrp_pkg::side_t   sq_side;

  atrp_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_valid_r),
    .in_sum    (s3_sum_r),
    .in_side   (s3_side_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // atan2 operands, all with 8 fraction bits
  logic signed [OP_W-1:0] op_x, op_y, op_z, op_neg_x, op_root;
  logic signed [OP_W-1:0] roll_den, pitch_den;

  always_comb begin
    op_x      = OP_W'(sq_side.ax) <<< FRAC_W;
    op_y      = OP_W'(sq_side.ay) <<< FRAC_W;
    op_z      = OP_W'(sq_side.az) <<< FRAC_W;
    op_neg_x  = -op_x;
    op_root   = $signed(OP_W'(sq_root));
    roll_den  = sq_side.mode ? op_z : op_root;
    pitch_den = sq_side.mode ? op_root : op_z;
  end

  logic                                roll_valid, pitch_valid;
  logic signed [atrp_pkg::ANGLE_W-1:0] roll_angle, pitch_angle;

  atrp_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_num    (op_y),
    .in_den    (roll_den),
    .out_valid (roll_valid),
    .out_angle (roll_angle)
  );

  atrp_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (sq_valid),
    .in_num    (op_neg_x),
    .in_den    (pitch_den),
    .out_valid (pitch_valid),
    .out_angle (pitch_angle)
  );

  // output register plus skid register
  logic                pipe_valid;
  atrp_pkg::out_word_t pipe_word;
  logic                out_valid_r, out_valid_nxt;
  atrp_pkg::out_word_t out_word_r, out_word_nxt, skid_word_r, skid_word_nxt;

  always_comb begin
    pipe_valid            = roll_valid & pitch_valid;   // lanes run in lock step
    pipe_word.roll_angle  = roll_angle;
    pipe_word.pitch_angle = pitch_angle;

    out_valid_nxt  = out_valid_r;
    out_word_nxt   = out_word_r;
    skid_valid_nxt = skid_valid_r;
    skid_word_nxt  = skid_word_r;
    if (skid_valid_r) begin
      // pipeline frozen; drain skid once the output word is taken
      if (!out_stall) begin
        out_word_nxt   = skid_word_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || !out_stall) begin
      out_valid_nxt = pipe_valid;
      out_word_nxt  = pipe_word;
    end else begin
      // output held: park the word leaving the pipeline
      skid_valid_nxt = pipe_valid;
      skid_word_nxt  = pipe_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r  <= out_word_nxt;
    skid_word_r <= skid_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[hdl/atrp_checker.sv]
// Port-level checker for the tilt block, bound to the top level.
`include "accel_tilt_roll_pitch_top_macros.svh"

module atrp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input atrp_pkg::out_word_t out_word
);

  localparam int AW = atrp_pkg::ANGLE_W;
  localparam logic signed [AW-1:0] LIM_POS = AW'(atrp_pkg::ANGLE_LIMIT);
  localparam logic signed [AW-1:0] LIM_NEG = AW'(-atrp_pkg::ANGLE_LIMIT);

  // held result word keeps its valid and value
  `ATRP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "output word changed while stalled")

  // angles stay within +/-180 degrees
  `ATRP_ASSERT_NOW(a_angle_range, out_valid, (out_word.roll_angle <= LIM_POS) && (out_word.roll_angle >= LIM_NEG) && (out_word.pitch_angle <= LIM_POS) && (out_word.pitch_angle >= LIM_NEG), "angle outside +/-180 degrees")

  // the skid only fills behind a held output word
  `ATRP_ASSERT_NOW(a_stall_needs_out, !out_valid, !in_stall, "input stalled with no output word")

  // input stall only follows a stalled output
  `ATRP_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall), "input stall without output stall")

endmodule

bind accel_tilt_roll_pitch_top atrp_checker u_atrp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);
